FILE: design/bd_pkg.sv
// ----------------------------------------------------------------------------
// bd_pkg
// Shared types and codes for the bounded deque: actions, status codes,
// controller states and the controller/datapath command and status groups.
// ----------------------------------------------------------------------------
`default_nettype none

package bd_pkg;

  localparam int unsigned ActionWidth = 2;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned OccWidth    = 4;
  localparam int unsigned PortWidth   = 32;

  typedef enum logic [ActionWidth-1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } action_e;

  typedef enum logic [StatusWidth-1:0] {
    STAT_DONE         = 2'd0,
    STAT_REFUSE_FULL  = 2'd1,
    STAT_REFUSE_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic exec;
    logic capture;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_read;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: design/bd_ctrl.sv
// ----------------------------------------------------------------------------
// bd_ctrl
// Controller: accepts one beat at a time, waits for the store read on a
// pop from a non-empty store, then holds the result beat until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  bd_pkg::dp_status_t dp_status_i,
  output bd_pkg::ctrl_cmd_t  cmd_o
);
  import bd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = dp_status_i.need_read ? ST_READ : ST_RESP;
        end
      end
      ST_READ: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_o    = 1'b1;
    out_valid_o   = 1'b0;
    cmd_o.exec    = 1'b0;
    cmd_o.capture = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.exec = in_valid_i;
      end
      ST_READ: begin
        cmd_o.capture = 1'b1;
      end
      ST_RESP: begin
        out_valid_o = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  a_resp_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result is pending");

  a_read_then_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> out_valid_o)
    else $error("captured read not presented");

  a_exec_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.exec && !dp_status_i.need_read) |=> out_valid_o)
    else $error("result missing after non-read action");

endmodule

`default_nettype wire

FILE: design/bd_datapath.sv
// ----------------------------------------------------------------------------
// bd_datapath
// Datapath: circular store with head/tail indices, occupancy count and
// the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bd_datapath #(
  parameter int unsigned DEPTH      = 8,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bd_pkg::ctrl_cmd_t                   cmd_i,
  output bd_pkg::dp_status_t                  status_o,
  input  logic [bd_pkg::ActionWidth-1:0]      action_i,
  input  logic signed [bd_pkg::PortWidth-1:0] push_value_i,
  output logic signed [bd_pkg::PortWidth-1:0] result_value_o,
  output logic [bd_pkg::StatusWidth-1:0]      status_code_o,
  output logic [bd_pkg::OccWidth-1:0]         occupancy_o
);
  import bd_pkg::*;

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_q;

  logic [IW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;

  logic signed [PortWidth-1:0] result_q, result_d;
  logic [StatusWidth-1:0]      stat_q, stat_d;
  logic [OccWidth-1:0]         occ_q;

  logic                  we, re;
  logic [IW-1:0]         waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [63:0]           push_ext;
  logic [63:0]           push_out64, rd_out64;
  logic                  is_empty, is_full, is_push;
  action_e               act;

  assign act      = action_e'(action_i);
  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CW'(DEPTH));
  assign is_push  = (act == ACT_PUSH_FRONT) || (act == ACT_PUSH_BACK);

  assign push_ext   = 64'(push_value_i);
  assign wdata      = push_ext[DATA_WIDTH-1:0];
  assign push_out64 = 64'($signed(wdata));
  assign rd_out64   = 64'($signed(rd_q));

  assign status_o.need_read = !is_push && !is_empty;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] i);
    wrap_inc = (i == IW'(DEPTH - 1)) ? '0 : i + IW'(1);
  endfunction

  function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] i);
    wrap_dec = (i == '0) ? IW'(DEPTH - 1) : i - IW'(1);
  endfunction

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    result_d = '0;
    stat_d   = STAT_DONE;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = '0;
    raddr    = (act == ACT_POP_FRONT) ? head_q : tail_q;
    if (is_push) begin
      if (is_full) begin
        stat_d = STAT_REFUSE_FULL;
      end else begin
        we       = 1'b1;
        count_d  = count_q + CW'(1);
        result_d = push_out64[PortWidth-1:0];
        if (is_empty) begin
          head_d = '0;
          tail_d = '0;
          waddr  = '0;
        end else if (act == ACT_PUSH_FRONT) begin
          head_d = wrap_dec(head_q);
          waddr  = head_d;
        end else begin
          tail_d = wrap_inc(tail_q);
          waddr  = tail_d;
        end
      end
    end else begin
      if (is_empty) begin
        stat_d = STAT_REFUSE_EMPTY;
      end else begin
        re      = 1'b1;
        count_d = count_q - CW'(1);
        if (head_q == tail_q) begin
          head_d = '0;
          tail_d = '0;
        end else if (act == ACT_POP_FRONT) begin
          head_d = wrap_inc(head_q);
        end else begin
          tail_d = wrap_dec(tail_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.exec && re) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.exec) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      result_q <= result_d;
      stat_q   <= stat_d;
      occ_q    <= OccWidth'(count_d);
    end else if (cmd_i.capture) begin
      result_q <= rd_out64[PortWidth-1:0];
    end
  end

  assign result_value_o = result_q;
  assign status_code_o  = stat_q;
  assign occupancy_o    = occ_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("occupancy above depth");

  a_empty_indices: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_empty |-> (head_q == '0 && tail_q == '0))
    else $error("empty store with nonzero indices");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && is_push && !is_full) |=> count_q == $past(count_q) + CW'(1))
    else $error("push did not advance occupancy");

endmodule

`default_nettype wire

FILE: design/bounded_deque.sv
// ----------------------------------------------------------------------------
// bounded_deque
// Bounded double-ended queue of signed words on a circular store.
//
//   channel  direction  handshake                fields
//   in       input      in_valid_i / in_stall_o  action_i, push_value_i
//   out      output     out_valid_o / out_stall_i result_value_o, status_o,
//                                                  occupancy_o
//
// A push or a refused action raises the result beat in the cycle after accept;
// a pop first passes the READ state for the registered store read port. One beat
// is in flight at a time; the next input is taken the cycle after the
// result beat leaves.
// Reset empties the deque at once; store contents are not cleared.
// An out stall holds the result and keeps the input stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque #(
  parameter int unsigned DEPTH      = 8,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [bd_pkg::ActionWidth-1:0]      action_i,
  input  logic signed [bd_pkg::PortWidth-1:0] push_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [bd_pkg::PortWidth-1:0] result_value_o,
  output logic [bd_pkg::StatusWidth-1:0]      status_o,
  output logic [bd_pkg::OccWidth-1:0]         occupancy_o
);
  import bd_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  bd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dp_status_i (dp_status),
    .cmd_o       (cmd)
  );

  bd_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (dp_status),
    .action_i       (action_i),
    .push_value_i   (push_value_i),
    .result_value_o (result_value_o),
    .status_code_o  (status_o),
    .occupancy_o    (occupancy_o)
  );

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bounded_deque. A behavioral deque inside the bench
// predicts value, status and occupancy for each accepted beat. Directed tests
// cover empty pops, full pushes, wrap of both indices and the word extremes.
// A random walk then drifts between full and empty with random gaps on the
// input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bd_pkg::*;

  localparam int unsigned Depth      = 8;
  localparam int unsigned RandomBeats = 1800;

  typedef struct {
    logic [PortWidth-1:0] value;
    status_e              status;
    logic [OccWidth-1:0]  occupancy;
  } deque_result_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [ActionWidth-1:0]      action_i;
  logic signed [PortWidth-1:0] push_value_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic signed [PortWidth-1:0] result_value_o;
  logic [StatusWidth-1:0]      status_o;
  logic [OccWidth-1:0]         occupancy_o;

  logic [PortWidth-1:0] deque_words [Depth];
  int unsigned          front_idx;
  int unsigned          back_idx;
  bit                   deque_empty;

  deque_result_t owed_results [$];
  int unsigned   errors_seen;
  bit            idle_on;

  bounded_deque u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .push_value_i  (push_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_value_o(result_value_o),
    .status_o      (status_o),
    .occupancy_o   (occupancy_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned words_held();
    if (deque_empty) return 0;
    if (back_idx >= front_idx) return back_idx - front_idx + 1;
    return Depth - front_idx + back_idx + 1;
  endfunction

  function automatic deque_result_t apply_action(action_e act, logic [PortWidth-1:0] word);
    deque_result_t r;
    int unsigned   at;
    r.value  = '0;
    r.status = STAT_DONE;
    if (act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK) begin
      if (words_held() >= Depth) begin
        r.status = STAT_REFUSE_FULL;
      end else begin
        if (deque_empty) begin
          front_idx      = 0;
          back_idx       = 0;
          deque_words[0] = word;
          deque_empty    = 1'b0;
        end else if (act == ACT_PUSH_FRONT) begin
          front_idx = (front_idx == 0) ? Depth - 1 : front_idx - 1;
          deque_words[front_idx] = word;
        end else begin
          back_idx = (back_idx == Depth - 1) ? 0 : back_idx + 1;
          deque_words[back_idx] = word;
        end
        r.value = word;
      end
    end else begin
      if (deque_empty) begin
        r.status = STAT_REFUSE_EMPTY;
      end else begin
        at      = (act == ACT_POP_FRONT) ? front_idx : back_idx;
        r.value = deque_words[at];
        if (front_idx == back_idx) begin
          front_idx   = 0;
          back_idx    = 0;
          deque_empty = 1'b1;
        end else if (act == ACT_POP_FRONT) begin
          front_idx = (front_idx == Depth - 1) ? 0 : front_idx + 1;
        end else begin
          back_idx = (back_idx == 0) ? Depth - 1 : back_idx - 1;
        end
      end
    end
    r.occupancy = OccWidth'(words_held());
    return r;
  endfunction

  function automatic int unsigned idle_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [PortWidth-1:0] pick_word();
    case ($urandom_range(0, 19))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(action_e act, logic [PortWidth-1:0] word);
    int unsigned gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 1) == 0) gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    push_value_i <= word;
    owed_results.push_back(apply_action(act, word));
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic test_empty_refusals();
    send_beat(ACT_POP_FRONT, $urandom);
    send_beat(ACT_POP_BACK, $urandom);
  endtask

  task automatic test_fill_and_overflow();
    send_beat(ACT_PUSH_FRONT, 32'h7fff_ffff);
    send_beat(ACT_PUSH_FRONT, 32'h8000_0000);
    send_beat(ACT_PUSH_BACK, 32'hffff_ffff);
    send_beat(ACT_PUSH_BACK, 32'h0000_0000);
    send_beat(ACT_PUSH_FRONT, $urandom);
    send_beat(ACT_PUSH_BACK, $urandom);
    send_beat(ACT_PUSH_FRONT, $urandom);
    send_beat(ACT_PUSH_BACK, $urandom);
    send_beat(ACT_PUSH_FRONT, $urandom);
    send_beat(ACT_PUSH_BACK, $urandom);
  endtask

  task automatic test_drain_to_empty();
    for (int i = 0; i < Depth; i++) begin
      send_beat((i % 2 == 0) ? ACT_POP_FRONT : ACT_POP_BACK, $urandom);
    end
    send_beat(ACT_POP_BACK, $urandom);
    send_beat(ACT_PUSH_BACK, $urandom);
  endtask

  task automatic test_random_walk();
    int unsigned sent;
    int unsigned seg_len;
    int unsigned push_pct;
    action_e     act;
    sent = 0;
    while (sent < RandomBeats) begin
      seg_len = $urandom_range(20, 80);
      case ($urandom_range(0, 2))
        0:       push_pct = 80;
        1:       push_pct = 20;
        default: push_pct = 50;
      endcase
      idle_on = ($urandom_range(0, 4) != 0);
      for (int i = 0; i < seg_len; i++) begin
        if ($urandom_range(0, 99) < push_pct) begin
          act = ($urandom_range(0, 1) == 0) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
        end else begin
          act = ($urandom_range(0, 1) == 0) ? ACT_POP_FRONT : ACT_POP_BACK;
        end
        send_beat(act, pick_word());
      end
      sent += seg_len;
    end
    idle_on = 1'b1;
  endtask

  initial begin
    int unsigned run_left;
    bit          stall_now;
    run_left  = 0;
    stall_now = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (run_left == 0) begin
        if (!stall_now && idle_on) begin
          stall_now = 1'b1;
          run_left  = idle_len();
        end else begin
          stall_now = 1'b0;
          run_left  = $urandom_range(1, 10);
        end
      end
      run_left--;
      out_stall_i <= stall_now;
    end
  end

  always @(posedge clk_i) begin
    deque_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_results.size() == 0) begin
        $error("result beat with nothing expected: value %0d status %0d occupancy %0d",
               result_value_o, status_o, occupancy_o);
        errors_seen++;
      end else begin
        want = owed_results.pop_front();
        if (result_value_o !== want.value) begin
          $error("result_value: expected %0d, got %0d", $signed(want.value), result_value_o);
          errors_seen++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          errors_seen++;
        end
        if (occupancy_o !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy_o);
          errors_seen++;
        end
      end
    end
  end

  initial begin
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    action_i     <= ACT_PUSH_FRONT;
    push_value_i <= '0;
    errors_seen  = 0;
    idle_on      = 1'b1;
    front_idx    = 0;
    back_idx     = 0;
    deque_empty  = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_refusals();
    test_fill_and_overflow();
    test_drain_to_empty();
    test_random_walk();

    in_valid_i <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors_seen == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: bounded_deque.f
design/bd_pkg.sv
design/bd_ctrl.sv
design/bd_datapath.sv
design/bounded_deque.sv
tb/tb.sv
